>>> rtl/alu8_pkg.sv
// Shared types and operation codes for the 8-bit ALU with flags.
// No dependencies; imported by the execute stage and the top level.
`timescale 1ns / 1ps

package alu8_pkg;

	localparam int ACT_W  = 5;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_OR  = 5'd0,
		ACT_AND = 5'd1,
		ACT_XOR = 5'd2,
		ACT_ADC = 5'd3,
		ACT_SBC = 5'd4,
		ACT_CMP = 5'd5,
		ACT_CPX = 5'd6,
		ACT_CPY = 5'd7,
		ACT_DEC = 5'd8,
		ACT_DEX = 5'd9,
		ACT_DEY = 5'd10,
		ACT_INC = 5'd11,
		ACT_INX = 5'd12,
		ACT_INY = 5'd13,
		ACT_ASL = 5'd14,
		ACT_ROL = 5'd15,
		ACT_LSR = 5'd16,
		ACT_ROR = 5'd17
	} action_t;

	// Architectural registers and flags
	typedef struct packed {
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] y;
		logic              c;
		logic              z;
		logic              n;
		logic              v;
	} alu8_state_t;

	// Memory write request
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} alu8_wr_t;

endpackage

>>> rtl/alu8_exec.sv
// Single-pass execute logic: next registers, flags and memory write for one instruction.
// Depends on alu8_pkg.
`timescale 1ns / 1ps

module alu8_exec (
	input  logic [alu8_pkg::ACT_W-1:0]  action,
	input  logic [alu8_pkg::BYTE_W-1:0] operand,
	input  logic                        target_accumulator,
	input  logic [alu8_pkg::ADDR_W-1:0] address,
	input  alu8_pkg::alu8_state_t       cur,
	output alu8_pkg::alu8_state_t       nxt,
	output alu8_pkg::alu8_wr_t          wr
);
	import alu8_pkg::*;

	logic [BYTE_W-1:0] add_b;
	logic [BYTE_W:0]   sum;
	logic              add_v;
	logic [BYTE_W-1:0] cmp_reg;
	logic [BYTE_W:0]   diff;
	logic [BYTE_W-1:0] res;
	logic              set_nz;
	logic [BYTE_W-1:0] shf;
	logic              shf_c;

	// Subtract is add of the inverted operand; both share one adder
	assign add_b = (action == ACT_SBC) ? ~operand : operand;
	assign sum   = {1'b0, cur.acc} + {1'b0, add_b} + {{BYTE_W{1'b0}}, cur.c};
	assign add_v = ~(cur.acc[BYTE_W-1] ^ add_b[BYTE_W-1]) & (cur.acc[BYTE_W-1] ^ sum[BYTE_W-1]);

	always_comb begin
		case (action)
			ACT_CPX: cmp_reg = cur.x;
			ACT_CPY: cmp_reg = cur.y;
			default: cmp_reg = cur.acc;
		endcase
	end

	// Carry out of reg + ~m + 1 is reg >= m
	assign diff = {1'b0, cmp_reg} + {1'b0, ~operand} + {{BYTE_W{1'b0}}, 1'b1};

	always_comb begin
		case (action)
			ACT_ASL: begin
				shf   = {operand[BYTE_W-2:0], 1'b0};
				shf_c = operand[BYTE_W-1];
			end
			ACT_ROL: begin
				shf   = {operand[BYTE_W-2:0], cur.c};
				shf_c = operand[BYTE_W-1];
			end
			ACT_LSR: begin
				shf   = {1'b0, operand[BYTE_W-1:1]};
				shf_c = operand[0];
			end
			default: begin
				shf   = {cur.c, operand[BYTE_W-1:1]};
				shf_c = operand[0];
			end
		endcase
	end

	always_comb begin
		nxt     = cur;
		wr.we   = 1'b0;
		res     = '0;
		set_nz  = 1'b1;
		case (action)
			ACT_OR: begin
				res     = cur.acc | operand;
				nxt.acc = res;
			end
			ACT_AND: begin
				res     = cur.acc & operand;
				nxt.acc = res;
			end
			ACT_XOR: begin
				res     = cur.acc ^ operand;
				nxt.acc = res;
			end
			ACT_ADC, ACT_SBC: begin
				res     = sum[BYTE_W-1:0];
				nxt.acc = res;
				nxt.c   = sum[BYTE_W];
				nxt.v   = add_v;
			end
			ACT_CMP, ACT_CPX, ACT_CPY: begin
				res   = diff[BYTE_W-1:0];
				nxt.c = diff[BYTE_W];
			end
			ACT_DEC: begin
				res   = operand - 8'd1;
				wr.we = 1'b1;
			end
			ACT_INC: begin
				res   = operand + 8'd1;
				wr.we = 1'b1;
			end
			ACT_DEX: begin
				res   = cur.x - 8'd1;
				nxt.x = res;
			end
			ACT_DEY: begin
				res   = cur.y - 8'd1;
				nxt.y = res;
			end
			ACT_INX: begin
				res   = cur.x + 8'd1;
				nxt.x = res;
			end
			ACT_INY: begin
				res   = cur.y + 8'd1;
				nxt.y = res;
			end
			ACT_ASL, ACT_ROL, ACT_LSR, ACT_ROR: begin
				res   = shf;
				nxt.c = shf_c;
				if (target_accumulator) begin
					nxt.acc = shf;
				end else begin
					wr.we = 1'b1;
				end
			end
			default: begin
				set_nz = 1'b0;
			end
		endcase
		if (set_nz) begin
			nxt.z = (res == '0);
			nxt.n = res[BYTE_W-1];
		end
		// Zero the request fields when nothing is written
		wr.addr = wr.we ? address : '0;
		wr.data = wr.we ? res : '0;
	end

endmodule

>>> rtl/cpu_alu_8bit_with_flags_unit.sv
// Top level of the 8-bit ALU with flags: stream ports, input and result registers, state.
// Depends on alu8_pkg and alu8_exec.
`timescale 1ns / 1ps

// Executes one ALU instruction per input transaction against the kept A, X, Y and
// carry, zero, negative and overflow flags, and returns one result transaction per
// instruction holding the registers and flags after it plus an optional memory write.
// Throughput is one instruction per clock unless m_tready stalls the output; each
// instruction passes the input register, then the result register. The rate is set by
// the single ALU pass whose result feeds A and the flags back for the next instruction.
// While a finished result waits on the output, the input register takes one more
// transaction if it is empty and then holds s_tready low until the result is taken.
module cpu_alu_8bit_with_flags_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] action, [12:5] operand, [28:13] address, [31:29] zero
	input  logic [31:0] s_tdata,
	// [0] target_accumulator
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] acc, [15:8] x_reg, [23:16] y_reg, [24] carry, [25] zero, [26] negative,
	// [27] overflow, [43:28] write_address, [51:44] write_data, [55:52] zero
	output logic [55:0] m_tdata,
	// [0] write_enable
	output logic        m_tuser
);
	import alu8_pkg::*;

	logic              vld_s1;
	logic [ACT_W-1:0]  act_s1;
	logic [BYTE_W-1:0] opnd_s1;
	logic              tacc_s1;
	logic [ADDR_W-1:0] addr_s1;

	alu8_state_t       state_q;
	alu8_state_t       state_nxt;
	alu8_wr_t          wr_nxt;

	logic              vld_s2;
	alu8_state_t       res_s2;
	alu8_wr_t          wr_s2;

	logic              advance;

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	alu8_exec u_exec (
		.action             (act_s1),
		.operand            (opnd_s1),
		.target_accumulator (tacc_s1),
		.address            (addr_s1),
		.cur                (state_q),
		.nxt                (state_nxt),
		.wr                 (wr_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= s_tdata[4:0];
			opnd_s1 <= s_tdata[12:5];
			addr_s1 <= s_tdata[28:13];
			tacc_s1 <= s_tuser;
		end
	end

	// Commit the architectural state as the instruction leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			vld_s2  <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= state_nxt;
			wr_s2  <= wr_nxt;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = wr_s2.we;
	assign m_tdata  = {4'b0000, wr_s2.data, wr_s2.addr, res_s2.v, res_s2.n, res_s2.z,
		res_s2.c, res_s2.y, res_s2.x, res_s2.acc};

endmodule
